### hdl/stq_pkg.sv
// stq_pkg: shared types, sizes and codes for the sorted timer queue
// used by stq_core and sorted_timer_queue; depends on nothing else

package stq_pkg;

  // queue geometry
  localparam int CAPACITY  = 16;
  localparam int TIME_BITS = 32;
  localparam int ID_BITS   = 8;
  localparam int IDX_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS  = $clog2(CAPACITY + 1);

  // stream word layout
  localparam int FUNC_W      = 2;
  localparam int TID_W       = 8;
  localparam int TFIELD_W    = 32;
  localparam int STATUS_W    = 3;
  localparam int OUT_ID_W    = 8;
  localparam int S_TDATA_W   = 72;
  localparam int M_TDATA_W   = 8;
  localparam int TID_LO      = 0;
  localparam int EXP_LO      = TID_LO + TID_W;
  localparam int NOW_LO      = EXP_LO + TFIELD_W;

  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [TIME_BITS-1:0] tm_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_ADJUST = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_TICK   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_FULL    = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_DUP     = 3'd3,
    ST_EXPIRED = 3'd4,
    ST_NONE    = 3'd5
  } status_e;

  typedef struct packed {
    id_t id;
    tm_t expiry;
  } entry_t;

  typedef struct packed {
    func_e func;
    id_t   id;
    tm_t   expiry;
    tm_t   now;
  } cmd_t;

  typedef struct packed {
    status_e               status;
    logic [OUT_ID_W-1:0]   id;
    logic                  last;
  } res_t;

endpackage

### hdl/stq_core.sv
// stq_core: entry memory plus the sequencer that walks it for every operation
// depends on stq_pkg

module stq_core import stq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_ready_o,
  output logic res_valid_o,
  output res_t res_o,
  input  logic res_ready_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIND   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_PLACE  = 3'd4;
  localparam logic [2:0] S_TSCAN  = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  localparam cnt_t ONE = cnt_t'(1);
  localparam cnt_t CAP = cnt_t'(CAPACITY);

  logic [2:0] state_q, state_d;
  cnt_t       idx_q, idx_d;
  cnt_t       k_q, k_d;
  cnt_t       count_q, count_d;
  status_e    st_q, st_d;
  func_e      func_q;
  id_t        id_q;
  tm_t        exp_q;
  tm_t        now_q;

  entry_t     mem [CAPACITY];
  entry_t     rdata_q;
  entry_t     wdata;
  entry_t     new_entry;
  cnt_t       raddr;
  cnt_t       waddr;
  logic       we;
  cnt_t       ins_base;
  logic       res_valid;
  res_t       res;

  assign new_entry = '{id: id_q, expiry: exp_q};
  // entries left once a removal pass completes
  assign ins_base  = count_q - k_q;

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr[IDX_BITS-1:0]] <= wdata;
    end
    rdata_q <= mem[raddr[IDX_BITS-1:0]];
  end

  // operation word captured at accept
  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && state_q == S_IDLE) begin
      func_q <= cmd_i.func;
      id_q   <= cmd_i.id;
      exp_q  <= cmd_i.expiry;
      now_q  <= cmd_i.now;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    k_d         = k_q;
    count_d     = count_q;
    st_d        = st_q;
    raddr       = idx_q;
    we          = 1'b0;
    waddr       = idx_q;
    wdata       = rdata_q;
    res_valid   = 1'b0;
    res         = '{status: ST_DONE, id: '0, last: 1'b0};
    cmd_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          idx_d   = '0;
          k_d     = '0;
          raddr   = '0;
          state_d = (cmd_i.func == FUNC_TICK) ? S_TSCAN : S_FIND;
        end
      end
      // linear search for the id, one entry a cycle
      S_FIND: begin
        if (idx_q >= count_q) begin
          if (func_q != FUNC_ADD) begin
            st_d    = ST_UNKNOWN;
            state_d = S_RESP;
          end else if (count_q == CAP) begin
            st_d    = ST_FULL;
            state_d = S_RESP;
          end else if (count_q == '0) begin
            idx_d   = '0;
            state_d = S_PLACE;
          end else begin
            idx_d   = count_q - ONE;
            raddr   = count_q - ONE;
            state_d = S_INSERT;
          end
        end else if (rdata_q.id == id_q) begin
          if (func_q == FUNC_ADD) begin
            st_d    = ST_DUP;
            state_d = S_RESP;
          end else begin
            k_d     = ONE;
            idx_d   = idx_q + ONE;
            raddr   = idx_q + ONE;
            state_d = S_SHIFT;
          end
        end else begin
          idx_d = idx_q + ONE;
          raddr = idx_q + ONE;
        end
      end
      // close a gap of k entries, reporting popped heads on a tick
      S_SHIFT: begin
        if (idx_q >= count_q) begin
          count_d = ins_base;
          if (func_q == FUNC_TICK) begin
            state_d = S_IDLE;
          end else if (func_q == FUNC_ADJUST) begin
            if (ins_base == '0) begin
              idx_d   = '0;
              state_d = S_PLACE;
            end else begin
              idx_d   = ins_base - ONE;
              raddr   = ins_base - ONE;
              state_d = S_INSERT;
            end
          end else begin
            st_d    = ST_DONE;
            state_d = S_RESP;
          end
        end else if (func_q == FUNC_TICK && idx_q < k_q) begin
          res_valid  = 1'b1;
          res.status = ST_EXPIRED;
          res.id     = OUT_ID_W'(rdata_q.id);
          res.last   = (idx_q == k_q - ONE);
          if (res_ready_i) begin
            idx_d = idx_q + ONE;
            raddr = idx_q + ONE;
          end
        end else begin
          we    = 1'b1;
          waddr = idx_q - k_q;
          wdata = rdata_q;
          idx_d = idx_q + ONE;
          raddr = idx_q + ONE;
        end
      end
      // walk back from the tail, moving later expiries up one slot
      S_INSERT: begin
        we    = 1'b1;
        waddr = idx_q + ONE;
        if (rdata_q.expiry > exp_q) begin
          wdata = rdata_q;
          if (idx_q == '0) begin
            state_d = S_PLACE;
          end else begin
            idx_d = idx_q - ONE;
            raddr = idx_q - ONE;
          end
        end else begin
          wdata   = new_entry;
          count_d = count_q + ONE;
          st_d    = ST_DONE;
          state_d = S_RESP;
        end
      end
      S_PLACE: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = new_entry;
        count_d = count_q + ONE;
        st_d    = ST_DONE;
        state_d = S_RESP;
      end
      // count the due entries at the head
      S_TSCAN: begin
        if (idx_q < count_q && rdata_q.expiry <= now_q) begin
          idx_d = idx_q + ONE;
          raddr = idx_q + ONE;
        end else if (idx_q == '0) begin
          st_d    = ST_NONE;
          state_d = S_RESP;
        end else begin
          k_d     = idx_q;
          idx_d   = '0;
          raddr   = '0;
          state_d = S_SHIFT;
        end
      end
      S_RESP: begin
        res_valid  = 1'b1;
        res.status = st_q;
        res.last   = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      k_q     <= '0;
      count_q <= '0;
      st_q    <= ST_DONE;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      k_q     <= k_d;
      count_q <= count_d;
      st_q    <= st_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

  // checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP)
    else $error("entry count above capacity");

  a_gap_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (k_q <= count_q && k_q != '0))
    else $error("removal gap larger than the queue");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSERT || state_q == S_PLACE) |-> (count_q < CAP))
    else $error("insert into a full queue");

  a_pop_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status == ST_EXPIRED) |-> (func_q == FUNC_TICK))
    else $error("expired word outside a tick");

endmodule

### hdl/sorted_timer_queue.sv
// sorted_timer_queue: stream wrapper with output register around stq_core
// depends on stq_pkg and stq_core
// every operation walks the entries held; a tick also waits on any output stall per popped word
// throughput: one operation at a time, bounded by the walk over the one-write, one-read entry memory
// reset: queue empty at once, no clearing pass; entry memory holds no reset value

module sorted_timer_queue import stq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] timer_id, [39:8] expire_time, [71:40] current_time
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [1:0] func
  input  logic [FUNC_W-1:0]    s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] expired_id
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [STATUS_W-1:0]  m_axis_tuser,
  output logic                 m_axis_tlast
);

  cmd_t cmd;
  logic res_valid;
  res_t res;
  logic res_ready;
  logic out_valid_q;
  res_t out_q;

  // unpack the incoming word
  assign cmd.func   = func_e'(s_axis_tuser);
  assign cmd.id     = ID_BITS'(s_axis_tdata[TID_LO +: TID_W]);
  assign cmd.expiry = TIME_BITS'(s_axis_tdata[EXP_LO +: TFIELD_W]);
  assign cmd.now    = TIME_BITS'(s_axis_tdata[NOW_LO +: TFIELD_W]);

  stq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_i       (cmd),
    .cmd_ready_o (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_q.id);
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tlast  = out_q.last;

endmodule
